// ----- rtl/ftbp_pkg.sv -----
// Shared types and constants for the float truncation bit packer.
// No dependencies; every other file imports this package.
package ftbp_pkg;

    localparam int unsigned FLOAT_W  = 32;
    localparam int unsigned MANT_W   = 23;
    localparam int unsigned KEEP_MIN = 9;     // sign plus exponent
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned MKEEP_W  = 5;
    localparam int unsigned KEEP_W   = 6;     // 9..32
    localparam int unsigned CNT_W    = 6;     // 0..39 bits pending
    localparam int unsigned ACC_W    = FLOAT_W + BYTE_W;
    localparam int unsigned Q_DEPTH  = 4;
    localparam int unsigned Q_AW     = $clog2(Q_DEPTH);
    localparam int unsigned Q_CW     = $clog2(Q_DEPTH + 1);

    localparam logic [MKEEP_W-1:0] MKEEP_MAX = MKEEP_W'(MANT_W);

    // One classified float: kept bits left-aligned with low bits cleared.
    typedef struct packed {
        logic [FLOAT_W-1:0] kept;
        logic [KEEP_W-1:0]  keep;
        logic               last;
    } t_job;

endpackage

// ----- rtl/ftbp_if.sv -----
// Valid/ready channel interfaces for the packer's input, output and config.
// Depends on ftbp_pkg for field widths.
interface ftbp_in_if
    import ftbp_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic [FLOAT_W-1:0] float_bits;
    logic               final_item;

    modport source (output valid, output float_bits, output final_item, input ready);
    modport sink   (input valid, input float_bits, input final_item, output ready);
endinterface

interface ftbp_out_if
    import ftbp_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] packed_byte;
    logic              end_of_stream;

    modport source (output valid, output packed_byte, output end_of_stream, input ready);
    modport sink   (input valid, input packed_byte, input end_of_stream, output ready);
endinterface

interface ftbp_cfg_if
    import ftbp_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic [MKEEP_W-1:0] mantissa_keep;

    modport source (output valid, output mantissa_keep, input ready);
    modport sink   (input valid, input mantissa_keep, output ready);
endinterface

// ----- rtl/ftbp_front.sv -----
// Front end: holds the keep register, accepts floats and turns each into a
// job (masked kept bits, bit count, last flag). Depends on ftbp_pkg, ftbp_if.
module ftbp_front
    import ftbp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    ftbp_in_if.sink       i_in,
    ftbp_cfg_if.sink      i_cfg,
    output logic          o_job_valid,
    output t_job          o_job,
    input  logic          i_job_ready
);

    logic [MKEEP_W-1:0] r_mkeep;
    logic               r_valid;
    t_job               r_job;
    logic [MKEEP_W-1:0] m_sat;
    logic [MKEEP_W-1:0] drop;
    t_job               n_job;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_valid || i_job_ready;

    always_comb begin
        m_sat      = (r_mkeep > MKEEP_MAX) ? MKEEP_MAX : r_mkeep;
        drop       = MKEEP_MAX - m_sat;
        n_job.kept = i_in.float_bits & ({FLOAT_W{1'b1}} << drop);
        n_job.keep = KEEP_W'(KEEP_MIN) + KEEP_W'(m_sat);
        n_job.last = i_in.final_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mkeep <= MKEEP_MAX;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_mkeep <= i_cfg.mantissa_keep;
            end
            if (i_in.ready) begin
                r_valid <= i_in.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_job <= n_job;
        end
    end

    assign o_job_valid = r_valid;
    assign o_job       = r_job;

endmodule

// ----- rtl/ftbp_queue.sv -----
// Small job FIFO between front and back ends, register storage.
// Depends on ftbp_pkg.
module ftbp_queue
    import ftbp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_ready,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_CW-1:0] r_count;
    logic            do_push;
    logic            do_pop;

    assign o_ready = (r_count != Q_CW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + Q_CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - Q_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CW'(Q_DEPTH))
        else $error("queue count past depth");
    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_pop && !do_push |=> r_count == $past(r_count) - Q_CW'(1))
        else $error("queue pop lost");
`endif

endmodule

// ----- rtl/ftbp_back.sv -----
// Back end: bit accumulator that splices jobs and, unless the receiver stalls,
// drains one byte per cycle into a registered output stage. Depends on ftbp_pkg, ftbp_if.
module ftbp_back
    import ftbp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    input  t_job      i_job,
    output logic      o_job_pop,
    ftbp_out_if.source o_out
);

    logic [ACC_W-1:0]  r_acc;     // pending bits, MSB-aligned
    logic [CNT_W-1:0]  r_cnt;
    logic              r_last;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_eos;

    logic [ACC_W-1:0]  n_acc;
    logic [CNT_W-1:0]  n_cnt;
    logic              n_last;
    logic [ACC_W-1:0]  acc1;
    logic [CNT_W-1:0]  cnt1;
    logic              last1;
    logic              active;
    logic              out_free;
    logic              emit;
    logic [BYTE_W-1:0] emit_byte;
    logic              emit_eos;
    logic              done1;
    logic              pop;

    assign out_free = !r_out_valid || o_out.ready;
    assign active   = (r_cnt >= CNT_W'(BYTE_W)) || (r_last && r_cnt != '0);

    always_comb begin
        acc1      = r_acc;
        cnt1      = r_cnt;
        last1     = r_last;
        emit      = 1'b0;
        emit_byte = '0;
        emit_eos  = 1'b0;
        if (active && out_free) begin
            emit = 1'b1;
            if (r_cnt >= CNT_W'(BYTE_W)) begin
                emit_byte = r_acc[ACC_W-1 -: BYTE_W];
                acc1      = r_acc << BYTE_W;
                cnt1      = r_cnt - CNT_W'(BYTE_W);
                emit_eos  = r_last && (cnt1 == '0);
                if (emit_eos) begin
                    last1 = 1'b0;
                end
            end else begin
                // flush: leftover bits right-aligned in the final byte
                emit_byte = r_acc[ACC_W-1 -: BYTE_W] >> (4'(BYTE_W) - {1'b0, r_cnt[2:0]});
                emit_eos  = 1'b1;
                acc1      = '0;
                cnt1      = '0;
                last1     = 1'b0;
            end
        end
        done1 = !((cnt1 >= CNT_W'(BYTE_W)) || (last1 && cnt1 != '0));
        pop   = done1 && i_job_valid;
        n_acc  = acc1;
        n_cnt  = cnt1;
        n_last = last1;
        if (pop) begin
            // cnt1 is below one byte here
            n_acc  = acc1 | ({i_job.kept, {BYTE_W{1'b0}}} >> cnt1[2:0]);
            n_cnt  = cnt1 + CNT_W'(i_job.keep);
            n_last = i_job.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_cnt       <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
            r_last <= n_last;
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= emit_byte;
            r_out_eos  <= emit_eos;
        end
    end

    assign o_job_pop           = pop;
    assign o_out.valid         = r_out_valid;
    assign o_out.packed_byte   = r_out_byte;
    assign o_out.end_of_stream = r_out_eos;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(ACC_W - 1))
        else $error("accumulator count out of range");
    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && emit_eos && !pop |=> !r_last && r_cnt == '0)
        else $error("stream end left pending bits");
    a_idle_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !active |-> r_cnt < CNT_W'(BYTE_W) && (!r_last || r_cnt == '0))
        else $error("pending byte not drained");
`endif

endmodule

// ----- rtl/float_truncate_bit_packer_unit.sv -----
// Float truncation bit packer, top level.
// Instantiates ftbp_front, ftbp_queue and ftbp_back; uses ftbp_pkg, ftbp_if.
//
// Usage:
//   i_in  : one float32 pattern per beat (float_bits, final_item).
//   o_out : packed stream, one byte per beat, MSB-first; end_of_stream marks
//           the last byte of a tensor (leftover bits right-aligned in it).
//   i_cfg : mantissa_keep write, always ready; write only while idle.
//           Values above 23 act as 23.
// Each float keeps 9+m bits, so it yields one to five bytes. The back end
// drains one byte per cycle while the receiver does not stall; the front
// accepts a beat every cycle until the four-entry job queue fills.
// A beat reaches the output through the front job register, a queue entry,
// the accumulator and the output register.
// Reset (synchronous, active low) empties the queue and held-over bits and
// sets mantissa_keep to 23. When the receiver stalls, the output register
// holds its byte, the back end waits, and the queue then the front fill up
// before i_in.ready drops.
module float_truncate_bit_packer_unit
    import ftbp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    ftbp_in_if.sink    i_in,
    ftbp_cfg_if.sink   i_cfg,
    ftbp_out_if.source o_out
);

    logic f_valid;
    t_job f_job;
    logic q_ready;
    logic q_valid;
    t_job q_job;
    logic q_pop;

    ftbp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (i_cfg),
        .o_job_valid (f_valid),
        .o_job       (f_job),
        .i_job_ready (q_ready)
    );

    ftbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_job   (f_job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (q_pop)
    );

    ftbp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_job_pop   (q_pop),
        .o_out       (o_out)
    );

endmodule
